@@ rtl/dsu_pkg.sv @@
`default_nettype none

package dsu_pkg;

    localparam int IDX_W    = 10;
    localparam int RANK_W   = 4;
    localparam int CMD_W    = 2;

    localparam int DEFAULT_NUM_ELEMENTS = 1024;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // command code three behaves as find
    localparam logic [CMD_W-1:0] CMD_MAKE_SET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNION    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND     = 2'd2;

endpackage

`default_nettype wire

@@ rtl/dsu_ram.sv @@
`default_nettype none

module dsu_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // a read of the address being written returns the new data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/disjoint_set_union_engine_core.sv @@
`default_nettype none

// Union-find table with union by rank and path compression. Each request is
// make-set, union or find and yields one result (root, already_joined).
// Parent links and ranks live in two RAMs with registered reads; one small
// sequencer walks the parent RAM one link per cycle. Make-set of an element
// in range writes both tables as the request is accepted. A find walks from
// its element up to the root, then walks the path again to repoint each
// link at the root (a root skips the second pass). A union runs both finds
// back to back, then reads the two root ranks (the second rank step also
// writes the link) and publishes the result, skipping the rank steps when
// both already share a root. The core takes no new request until its result
// sits in the output register; a finished result waits there while the next
// request runs.
// Both tables are undefined after reset: no clearing pass, and an element
// must get a make-set before any other request touches it.
module disjoint_set_union_engine_core
    import dsu_pkg::*;
#(
    parameter int NUM_ELEMENTS = DEFAULT_NUM_ELEMENTS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CMD_W-1:0] command,
    input  wire logic [IDX_W-1:0] elem_a,
    input  wire logic [IDX_W-1:0] elem_b,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [IDX_W-1:0] root,
    output logic                  already_joined
);

    localparam int AW = $clog2(NUM_ELEMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_FIX,
        ST_RANK_A,
        ST_RANK_B,
        ST_DONE
    } state_t;

    function automatic logic in_range(input logic [IDX_W-1:0] x);
        return 32'(x) < 32'(NUM_ELEMENTS);
    endfunction

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [IDX_W-1:0]    a_reg, a_next;
    logic [IDX_W-1:0]    b_reg, b_next;
    logic                phase_reg, phase_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    node_reg, node_next;
    logic [IDX_W-1:0]    found_reg, found_next;
    logic [IDX_W-1:0]    pa_reg, pa_next;
    logic [IDX_W-1:0]    pb_reg, pb_next;
    logic [RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [IDX_W-1:0]    res_root_reg, res_root_next;
    logic                res_joined_reg, res_joined_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    root_reg, root_next;
    logic                joined_reg, joined_next;

    logic                find_done;
    logic [IDX_W-1:0]    find_val;

    logic                par_we;
    logic [IDX_W-1:0]    par_waddr_idx;
    logic [IDX_W-1:0]    par_wdata;
    logic [IDX_W-1:0]    par_raddr_idx;
    logic [IDX_W-1:0]    par_rdata;

    logic                rnk_we;
    logic [IDX_W-1:0]    rnk_waddr_idx;
    logic [RANK_W-1:0]   rnk_wdata;
    logic [IDX_W-1:0]    rnk_raddr_idx;
    logic [RANK_W-1:0]   rnk_rdata;

    dsu_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (AW'(par_waddr_idx)),
        .wdata (par_wdata),
        .raddr (AW'(par_raddr_idx)),
        .rdata (par_rdata)
    );

    dsu_ram #(
        .WIDTH (RANK_W),
        .DEPTH (NUM_ELEMENTS)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rnk_we),
        .waddr (AW'(rnk_waddr_idx)),
        .wdata (rnk_wdata),
        .raddr (AW'(rnk_raddr_idx)),
        .rdata (rnk_rdata)
    );

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign root           = root_reg;
    assign already_joined = joined_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        phase_next      = phase_reg;
        start_next      = start_reg;
        node_next       = node_reg;
        found_next      = found_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        rank_a_next     = rank_a_reg;
        res_root_next   = res_root_reg;
        res_joined_next = res_joined_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        root_next       = root_reg;
        joined_next     = joined_reg;

        find_done       = 1'b0;
        find_val        = start_reg;

        par_we          = 1'b0;
        par_waddr_idx   = node_reg;
        par_wdata       = found_reg;
        par_raddr_idx   = node_reg;
        rnk_we          = 1'b0;
        rnk_waddr_idx   = pb_reg;
        rnk_wdata       = rnk_rdata;
        rnk_raddr_idx   = pa_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                par_raddr_idx = elem_a;
                if (in_valid)
                begin
                    cmd_next        = command;
                    a_next          = elem_a;
                    b_next          = elem_b;
                    phase_next      = 1'b0;
                    start_next      = elem_a;
                    node_next       = elem_a;
                    res_root_next   = elem_a;
                    res_joined_next = 1'b0;
                    if (command == CMD_MAKE_SET)
                    begin
                        if (in_range(elem_a))
                        begin
                            par_we        = 1'b1;
                            par_waddr_idx = elem_a;
                            par_wdata     = elem_a;
                            rnk_we        = 1'b1;
                            rnk_waddr_idx = elem_a;
                            rnk_wdata     = '0;
                        end
                        state_next = ST_DONE;
                    end
                    else if (!in_range(elem_a))
                    begin
                        // out-of-range element stands alone and is never stored
                        res_joined_next = (command == CMD_UNION) && (elem_a == elem_b);
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEEK;
                    end
                end
            end

            ST_SEEK:
            begin
                if (par_rdata == node_reg)
                begin
                    if (node_reg == start_reg)
                    begin
                        find_done = 1'b1;
                        find_val  = node_reg;
                    end
                    else
                    begin
                        // root reached: walk the path again from the start
                        found_next    = node_reg;
                        node_next     = start_reg;
                        par_raddr_idx = start_reg;
                        state_next    = ST_FIX;
                    end
                end
                else if (!in_range(par_rdata))
                begin
                    find_done = 1'b1;
                    find_val  = start_reg;
                end
                else
                begin
                    node_next     = par_rdata;
                    par_raddr_idx = par_rdata;
                end
            end

            ST_FIX:
            begin
                par_we        = 1'b1;
                par_waddr_idx = node_reg;
                par_wdata     = found_reg;
                if (par_rdata == found_reg)
                begin
                    find_done = 1'b1;
                    find_val  = found_reg;
                end
                else
                begin
                    node_next     = par_rdata;
                    par_raddr_idx = par_rdata;
                end
            end

            ST_RANK_A:
            begin
                rank_a_next   = rnk_rdata;
                rnk_raddr_idx = pb_reg;
                state_next    = ST_RANK_B;
            end

            ST_RANK_B:
            begin
                par_we = 1'b1;
                if (rank_a_reg <= rnk_rdata)
                begin
                    par_waddr_idx = pa_reg;
                    par_wdata     = pb_reg;
                    res_root_next = pb_reg;
                    // tie: the second root grows, saturating at the top rank
                    if ((rank_a_reg == rnk_rdata) && (rnk_rdata != RANK_MAX))
                    begin
                        rnk_we        = 1'b1;
                        rnk_waddr_idx = pb_reg;
                        rnk_wdata     = rnk_rdata + RANK_W'(1);
                    end
                end
                else
                begin
                    par_waddr_idx = pb_reg;
                    par_wdata     = pa_reg;
                    res_root_next = pa_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    root_next      = res_root_reg;
                    joined_next    = res_joined_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (find_done)
        begin
            if (!phase_reg)
            begin
                pa_next       = find_val;
                res_root_next = find_val;
                if ((cmd_reg == CMD_UNION) && in_range(b_reg))
                begin
                    phase_next    = 1'b1;
                    start_next    = b_reg;
                    node_next     = b_reg;
                    par_raddr_idx = b_reg;
                    state_next    = ST_SEEK;
                end
                else
                begin
                    res_joined_next = (cmd_reg == CMD_UNION) && (a_reg == b_reg);
                    state_next      = ST_DONE;
                end
            end
            else
            begin
                pb_next = find_val;
                if (find_val == pa_reg)
                begin
                    res_root_next   = pa_reg;
                    res_joined_next = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rnk_raddr_idx = pa_reg;
                    state_next    = ST_RANK_A;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            phase_reg      <= phase_next;
            start_reg      <= start_next;
            node_reg       <= node_next;
            found_reg      <= found_next;
            pa_reg         <= pa_next;
            pb_reg         <= pb_next;
            rank_a_reg     <= rank_a_next;
            res_root_reg   <= res_root_next;
            res_joined_reg <= res_joined_next;
            root_reg       <= root_next;
            joined_reg     <= joined_next;
        end
    end

    // the walk only ever follows links that stay inside the table
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SEEK) || (state_reg == ST_FIX)) |-> in_range(node_reg))
        else $error("walk node outside the table");

    // linking only happens between two distinct roots
    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RANK_A) || (state_reg == ST_RANK_B)) |-> (pa_reg != pb_reg))
        else $error("link step with equal roots");

    // already_joined is only ever reported for a union
    a_joined_union: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && res_joined_reg) |-> (cmd_reg == CMD_UNION))
        else $error("already_joined set on a non-union request");

    // a result is published only from the done state
    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !out_valid_reg) |-> (state_reg == ST_DONE))
        else $error("result published outside the done state");

    // the second find always starts from the union's second element
    a_second_find: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && (state_reg == ST_SEEK)) |-> (start_reg == b_reg))
        else $error("second find not started from elem_b");

endmodule

`default_nettype wire
